// ----- rtl/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the segment crossing checker.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int NUM_CELLS   = 4;
  localparam int CELL_STAGES = 3;
  localparam int OUT_COUNT_W = 11;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEST   = 2'd2
  } mode_t;

  // control word that travels down the cell row beside the segment data
  typedef struct packed {
    logic                 valid;
    logic [NUM_CELLS-1:0] pos;
    logic [NUM_CELLS-1:0] neg;
  } scc_ctl_t;

endpackage

// ----- rtl/scc_in_if.sv -----
// ----------------------------------------------------------------------------
// scc_in_if
// Input channel: command mode and one segment per transfer.
// ----------------------------------------------------------------------------
interface scc_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

// ----- rtl/scc_out_if.sv -----
// ----------------------------------------------------------------------------
// scc_out_if
// Result channel: crossing flag, dropped-append flag and table occupancy.
// ----------------------------------------------------------------------------
interface scc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            crosses;
  logic                            table_full;
  logic [scc_pkg::OUT_COUNT_W-1:0] stored_count;

  modport source (output valid, crosses, table_full, stored_count, input ready);
  modport sink   (input valid, crosses, table_full, stored_count, output ready);
endinterface

// ----- rtl/segment_crossing_checker_top.sv -----
// ----------------------------------------------------------------------------
// segment_crossing_checker_top
// Table of 2-D segments with clear, append and proper-crossing test.
// ----------------------------------------------------------------------------
// One item is handled at a time. A clear, an append or a test against an
// empty table gives its result in the cycle after the input transfer. A test
// against stored segments passes through a scan state, in which the single
// read port of the segment RAM streams one stored segment per cycle into a
// row of four orientation cells of three stages each, and a drain state, in
// which the row is drained before the result is shown.
// The result register frees the input side, so a new item is taken in the
// same cycle in which the previous result is transferred.
module segment_crossing_checker_top #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int COORD_BITS   = 16
) (
  input logic       clk,
  input logic       rst_n,
  scc_in_if.sink    in_ch,
  scc_out_if.source out_ch
);
  import scc_pkg::*;

  localparam int AW    = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_W = 4 * COORD_BITS;
  localparam int LAT   = NUM_CELLS * CELL_STAGES;
  localparam int DRN_W = $clog2(LAT + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [DRN_W-1:0]     drn_r, drn_nxt;
  logic                 hit_r, hit_nxt;
  logic                 issue_r, issue_nxt;
  logic [SEG_W-1:0]     p_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 crosses_r, crosses_nxt;
  logic                 full_r, full_nxt;
  logic [OUT_COUNT_W-1:0] count_r, count_nxt;
  logic                 finish;
  logic                 in_fire, out_fire;
  logic                 ram_we;
  logic [SEG_W-1:0]     seg_in;
  logic [SEG_W-1:0]     rdata;
  logic                 chain_hit;

  scc_ctl_t         chain_ctl  [NUM_CELLS+1];
  logic [SEG_W-1:0] chain_line [NUM_CELLS+1];
  logic [SEG_W-1:0] chain_seg  [NUM_CELLS+1];

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign seg_in = {in_ch.end_y, in_ch.end_x, in_ch.start_y, in_ch.start_x};

  scc_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (seg_in),
    .re    (state_r == ST_SCAN),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // cell row: tested segment as the line, stored segment as the other
  assign chain_ctl[0]  = '{valid: issue_r, pos: '0, neg: '0};
  assign chain_line[0] = p_r;
  assign chain_seg[0]  = rdata;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    scc_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (chain_ctl[i]),
      .line_i (chain_line[i]),
      .seg_i  (chain_seg[i]),
      .ctl_o  (chain_ctl[i+1]),
      .line_o (chain_line[i+1]),
      .seg_o  (chain_seg[i+1])
    );
  end

  // cells 0 and 2 see the two stored endpoints, 1 and 3 the tested ones,
  // each pair with one line reversed, so a crossing needs equal strict signs
  assign chain_hit = chain_ctl[NUM_CELLS].valid &&
    ((chain_ctl[NUM_CELLS].pos[3] && chain_ctl[NUM_CELLS].pos[1]) ||
     (chain_ctl[NUM_CELLS].neg[3] && chain_ctl[NUM_CELLS].neg[1])) &&
    ((chain_ctl[NUM_CELLS].pos[2] && chain_ctl[NUM_CELLS].pos[0]) ||
     (chain_ctl[NUM_CELLS].neg[2] && chain_ctl[NUM_CELLS].neg[0]));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    drn_nxt       = drn_r;
    hit_nxt       = hit_r || chain_hit;
    issue_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_fire;
    crosses_nxt   = crosses_r;
    full_nxt      = full_r;
    finish        = 1'b0;
    ram_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          crosses_nxt = 1'b0;
          full_nxt    = 1'b0;
          case (in_ch.mode)
            MODE_CLEAR: begin
              cnt_nxt = '0;
              finish  = 1'b1;
            end
            MODE_APPEND: begin
              if (cnt_r < CNT_W'(MAX_SEGMENTS)) begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end else begin
                full_nxt = 1'b1;
              end
              finish = 1'b1;
            end
            MODE_TEST: begin
              hit_nxt = 1'b0;
              if (cnt_r == '0) begin
                finish = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        issue_nxt = 1'b1;
        idx_nxt   = idx_r + CNT_W'(1);
        if (idx_r == cnt_r - CNT_W'(1)) begin
          drn_nxt   = DRN_W'(LAT);
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drn_r == '0) begin
          crosses_nxt = hit_r || chain_hit;
          full_nxt    = 1'b0;
          finish      = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          drn_nxt = drn_r - DRN_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
    count_nxt = finish ? OUT_COUNT_W'(cnt_nxt) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      drn_r       <= '0;
      hit_r       <= 1'b0;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      drn_r       <= drn_nxt;
      hit_r       <= hit_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crosses_r <= crosses_nxt;
    full_r    <= full_nxt;
    count_r   <= count_nxt;
    if (in_fire) begin
      p_r <= seg_in;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.crosses      = crosses_r;
  assign out_ch.table_full   = full_r;
  assign out_ch.stored_count = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count above table size");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r < cnt_r)
    else $error("scan index past stored segments");

  a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain_ctl[NUM_CELLS].valid |-> state_r == ST_SCAN || state_r == ST_DRAIN)
    else $error("cell row output outside a test");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && full_r |-> cnt_r == CNT_W'(MAX_SEGMENTS))
    else $error("dropped append with room in table");

endmodule

// ----- rtl/scc_ram.sv -----
// ----------------------------------------------------------------------------
// scc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/scc_cell.sv -----
// ----------------------------------------------------------------------------
// scc_cell
// One orientation cell: sign of the side of the other segment's start point
// relative to the directed line, then hands on (other swapped, line).
// ----------------------------------------------------------------------------
module scc_cell #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  scc_pkg::scc_ctl_t       ctl_i,
  input  logic [4*COORD_BITS-1:0] line_i,
  input  logic [4*COORD_BITS-1:0] seg_i,
  output scc_pkg::scc_ctl_t       ctl_o,
  output logic [4*COORD_BITS-1:0] line_o,
  output logic [4*COORD_BITS-1:0] seg_o
);
  import scc_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;

  logic signed [W-1:0]  ax, ay, bx, by, cx, cy;
  logic signed [DW-1:0] da_nxt, db_nxt, dc_nxt, dd_nxt;
  logic signed [DW-1:0] da_r, db_r, dc_r, dd_r;
  logic signed [PW-1:0] prod1_nxt, prod2_nxt;
  logic signed [PW-1:0] prod1_r, prod2_r;
  logic [4*W-1:0]       line_a_r, seg_a_r, line_b_r, seg_b_r;
  logic [4*W-1:0]       line_r, seg_r;
  scc_ctl_t             ctl_a_r, ctl_b_r, ctl_r, ctl_nxt;

  assign ax = $signed(line_i[0*W +: W]);
  assign ay = $signed(line_i[1*W +: W]);
  assign bx = $signed(line_i[2*W +: W]);
  assign by = $signed(line_i[3*W +: W]);
  assign cx = $signed(seg_i[0*W +: W]);
  assign cy = $signed(seg_i[1*W +: W]);

  assign da_nxt = DW'(bx) - DW'(ax);
  assign db_nxt = DW'(cy) - DW'(ay);
  assign dc_nxt = DW'(by) - DW'(ay);
  assign dd_nxt = DW'(cx) - DW'(ax);

  assign prod1_nxt = PW'(da_r) * PW'(db_r);
  assign prod2_nxt = PW'(dc_r) * PW'(dd_r);

  always_comb begin
    ctl_nxt       = ctl_b_r;
    ctl_nxt.pos   = {ctl_b_r.pos[NUM_CELLS-2:0], prod1_r > prod2_r};
    ctl_nxt.neg   = {ctl_b_r.neg[NUM_CELLS-2:0], prod1_r < prod2_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_r   <= '0;
    end else begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
      ctl_r   <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    da_r     <= da_nxt;
    db_r     <= db_nxt;
    dc_r     <= dc_nxt;
    dd_r     <= dd_nxt;
    line_a_r <= line_i;
    seg_a_r  <= seg_i;
    prod1_r  <= prod1_nxt;
    prod2_r  <= prod2_nxt;
    line_b_r <= line_a_r;
    seg_b_r  <= seg_a_r;
    // other segment with its endpoints swapped becomes the next line
    line_r   <= {seg_b_r[2*W-1:0], seg_b_r[4*W-1:2*W]};
    seg_r    <= line_b_r;
  end

  assign ctl_o  = ctl_r;
  assign line_o = line_r;
  assign seg_o  = seg_r;

endmodule

// ----- tb/sv/segment_crossing_checker_top_tb.sv -----
// ----------------------------------------------------------------------------
// segment_crossing_checker_top_tb
// Self-checking bench for the segment crossing checker. A short directed table
// covers the coordinate extremes, every mode, and the collinear, parallel,
// touching and zero-length cases. Random traffic of all four modes follows.
// Each result transfer is compared field by field against the result typed
// in its directed row if any, else an in-bench predictor on exact orientation
// signs. Several idle/stall mixes and one long receiver hold-off back up input.
// ----------------------------------------------------------------------------
module segment_crossing_checker_top_tb;
  import scc_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int CW          = 16;
  localparam int MAX_SEGS    = 1024;
  localparam int RAND_ITEMS  = 135;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 8_000_000;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic                   crosses;
    logic                   table_full;
    logic [OUT_COUNT_W-1:0] stored_count;
  } result_t;

  typedef struct packed {
    logic [1:0] mode;
    int         sx;
    int         sy;
    int         ex;
    int         ey;
    logic       typed;
    result_t    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  scc_in_if #(.COORD_BITS(CW)) in_ch();
  scc_out_if                   out_ch();

  segment_crossing_checker_top #(
    .MAX_SEGMENTS(MAX_SEGS),
    .COORD_BITS  (CW)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor copy of the segment table
  longint  tab_sx [MAX_SEGS];
  longint  tab_sy [MAX_SEGS];
  longint  tab_ex [MAX_SEGS];
  longint  tab_ey [MAX_SEGS];
  int      tab_count;

  result_t   outcome_q [$];
  stim_row_t directed_rows [$];
  int        fail_cnt;
  int        cycle_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        pressure_go;
  logic      hold_off;

  function automatic int side_of(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy);
    longint d;
    d = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    if (d > 0) return 1;
    if (d < 0) return -1;
    return 0;
  endfunction

  function automatic bit proper_cross(longint px1, longint py1, longint px2, longint py2,
                                      longint qx1, longint qy1, longint qx2, longint qy2);
    int o1, o2, o3, o4;
    o1 = side_of(px1, py1, px2, py2, qx1, qy1);
    o2 = side_of(px1, py1, px2, py2, qx2, qy2);
    if (o1 * o2 >= 0) return 1'b0;
    o3 = side_of(qx1, qy1, qx2, qy2, px1, py1);
    o4 = side_of(qx1, qy1, qx2, qy2, px2, py2);
    return (o3 * o4 < 0);
  endfunction

  function automatic result_t crossing_outcome(logic [1:0] m, coord_t sx, coord_t sy,
                                               coord_t ex, coord_t ey);
    result_t r;
    r = '0;
    case (m)
      MODE_CLEAR: tab_count = 0;
      MODE_APPEND: begin
        if (tab_count < MAX_SEGS) begin
          tab_sx[tab_count] = longint'(sx);
          tab_sy[tab_count] = longint'(sy);
          tab_ex[tab_count] = longint'(ex);
          tab_ey[tab_count] = longint'(ey);
          tab_count++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      MODE_TEST: begin
        for (int k = 0; k < tab_count; k++) begin
          if (proper_cross(longint'(sx), longint'(sy), longint'(ex), longint'(ey),
                           tab_sx[k], tab_sy[k], tab_ex[k], tab_ey[k])) begin
            r.crosses = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    r.stored_count = OUT_COUNT_W'(tab_count);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] m, int sx, int sy, int ex, int ey,
                                  logic typed, logic cr, logic fu, int cnt);
    stim_row_t row;
    row.mode             = m;
    row.sx               = sx;
    row.sy               = sy;
    row.ex               = ex;
    row.ey               = ey;
    row.typed            = typed;
    row.res.crosses      = cr;
    row.res.table_full   = fu;
    row.res.stored_count = OUT_COUNT_W'(cnt);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic coord_t rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom);
      4, 5, 6, 7: v = (int'($urandom_range(0, 8)) - 4) * 64;
      8: begin
        case ($urandom_range(0, 3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 2047)) - 1024;
    endcase
    return coord_t'(v);
  endfunction

  // one input transfer; valid stays high afterwards unless the next call idles
  task automatic send_item(logic [1:0] m, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                           logic typed, result_t typed_res);
    result_t pred;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.start_x <= sx;
    in_ch.start_y <= sy;
    in_ch.end_x   <= ex;
    in_ch.end_y   <= ey;
    do @(posedge clk); while (!in_ch.ready);
    pred = crossing_outcome(m, sx, sy, ex, ey);
    outcome_q.insert(outcome_q.size(), typed ? typed_res : pred);
  endtask

  task automatic send_plain(logic [1:0] m);
    send_item(m, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4)       send_plain(MODE_CLEAR);
    else if (pick < 8)  send_plain(MODE_UNUSED);
    else if (pick < 52) send_plain(MODE_APPEND);
    else                send_plain(MODE_TEST);
  endtask

  // receiver side
  always @(posedge clk) begin
    out_ch.ready <= !hold_off &&
                    !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    hold_off = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (outcome_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_cnt++;
      end else begin
        want = outcome_q.pop_front();
        if (out_ch.crosses !== want.crosses) begin
          $error("crosses: expected %0d, actual %0d", want.crosses, out_ch.crosses);
          fail_cnt++;
        end
        if (out_ch.table_full !== want.table_full) begin
          $error("table_full: expected %0d, actual %0d", want.table_full,
                 out_ch.table_full);
          fail_cnt++;
        end
        if (out_ch.stored_count !== want.stored_count) begin
          $error("stored_count: expected %0d, actual %0d", want.stored_count,
                 out_ch.stored_count);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("segment_crossing_checker_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    rst_n          = 1'b0;
    tab_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_go    = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_CLEAR;
    in_ch.start_x  = '0;
    in_ch.start_y  = '0;
    in_ch.end_x    = '0;
    in_ch.end_y    = '0;

    // mode, start x/y, end x/y, typed, crosses, table_full, stored_count
    add_row(MODE_TEST, -32768, -32768, 32767, 32767, 1, 0, 0, 0);
    add_row(MODE_APPEND, -32768, -32768, 32767, 32767, 1, 0, 0, 1);
    add_row(MODE_TEST, -32768, 32767, 32767, -32768, 0, 0, 0, 0);
    add_row(MODE_APPEND, 0, 0, 256, 256, 1, 0, 0, 2);
    // collinear, parallel, endpoint touch, point on segment
    add_row(MODE_TEST, -256, -256, 512, 512, 0, 0, 0, 0);
    add_row(MODE_TEST, 0, 256, 256, 512, 0, 0, 0, 0);
    add_row(MODE_TEST, 256, 256, 512, 0, 0, 0, 0, 0);
    add_row(MODE_TEST, 128, 128, 128, -512, 0, 0, 0, 0);
    // zero length
    add_row(MODE_TEST, 100, 100, 100, 100, 1, 0, 0, 2);
    add_row(MODE_APPEND, 5, 5, 5, 5, 1, 0, 0, 3);
    add_row(MODE_TEST, 0, 256, 256, 0, 0, 0, 0, 0);
    // axis aligned
    add_row(MODE_APPEND, 64, -512, 64, 512, 1, 0, 0, 4);
    add_row(MODE_TEST, -512, 64, 512, 64, 0, 0, 0, 0);
    add_row(MODE_UNUSED, 32767, -32768, -1, 0, 1, 0, 0, 4);
    add_row(MODE_APPEND, 32767, -32768, -32768, 32767, 1, 0, 0, 5);
    add_row(MODE_TEST, -32768, 0, 32767, 0, 0, 0, 0, 0);
    add_row(MODE_TEST, 21845, -21846, -21846, 21845, 0, 0, 0, 0);
    add_row(MODE_TEST, -32768, -32768, -32768, -32768, 0, 0, 0, 0);
    add_row(MODE_CLEAR, -1, -1, -1, -1, 1, 0, 0, 0);
    add_row(MODE_TEST, -32768, 32767, 32767, -32768, 1, 0, 0, 0);
    add_row(MODE_APPEND, 32767, 0, 0, 32767, 1, 0, 0, 1);
    add_row(MODE_TEST, 0, 0, 32767, 32767, 0, 0, 0, 0);
    add_row(MODE_UNUSED, 0, 0, 0, 0, 1, 0, 0, 1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.mode, coord_t'(row.sx), coord_t'(row.sy), coord_t'(row.ex),
                coord_t'(row.ey), row.typed, row.res);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          pressure_go    = 1'b1;
        end
        1: begin
          send_idle_pct  = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct  = 24;
          recv_stall_pct = 24;
        end
      endcase
      repeat (RAND_ITEMS) send_random();
    end

    in_ch.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("segment_crossing_checker_top_tb OK");
    end else begin
      $display("segment_crossing_checker_top_tb NOT OK");
    end
    $finish;
  end

endmodule
